// File: sv/b64d_pkg.sv
package b64d_pkg;

   // Default number of decoded groups held between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   typedef struct packed {
      logic [7:0] char_in;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_out;
   } rsp_type;

   // One decoded group: up to three bytes, byte 0 first. A count of zero is the end marker.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;
      logic            last;
   } group_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] d;
      r.hit   = 1'b1;
      r.value = '0;
      d       = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d       = c - CHAR_UPPER_A;
         r.value = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d       = c - CHAR_LOWER_A;
         r.value = d[5:0] + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d       = c - CHAR_DIGIT_0;
         r.value = d[5:0] + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         r.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.value = SEXTET_SLASH;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: sv/b64d_front.sv
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  b64d_pkg::req_type   req_data,
   output logic                group_push,
   output b64d_pkg::group_type group_data
);
   import b64d_pkg::*;

   logic [17:0] buffer_ff, buffer_in, buffer_post;
   logic [1:0]  count_ff, count_in, count_post;
   logic        stopped_ff, stopped_in, stopped_post;
   sextet_type  dec;
   logic        quad;
   logic [23:0] word;

   always_comb begin
      dec          = sextet_of(req_data.char_in);
      quad         = !stopped_ff && dec.hit && (count_ff == 2'd3);
      word         = {buffer_ff, dec.value};
      buffer_post  = buffer_ff;
      count_post   = count_ff;
      stopped_post = stopped_ff;
      if (!stopped_ff) begin
         if (!dec.hit) begin
            stopped_post = 1'b1;
         end else if (quad) begin
            buffer_post = '0;
            count_post  = '0;
         end else begin
            buffer_post = {buffer_ff[11:0], dec.value};
            count_post  = count_ff + 2'd1;
         end
      end
   end

   // A completed quad gives three bytes; the last character flushes whatever is left.
   always_comb begin
      group_data       = '0;
      group_data.last  = req_data.last_in;
      if (quad) begin
         group_data.bytes[0] = word[23:16];
         group_data.bytes[1] = word[15:8];
         group_data.bytes[2] = word[7:0];
         group_data.count    = 2'd3;
      end else if (req_data.last_in) begin
         case (count_post)
            2'd2: begin
               group_data.bytes[0] = buffer_post[11:4];
               group_data.count    = 2'd1;
            end
            2'd3: begin
               group_data.bytes[0] = buffer_post[17:10];
               group_data.bytes[1] = buffer_post[9:2];
               group_data.count    = 2'd2;
            end
            default: begin
               group_data.count = 2'd0;
            end
         endcase
      end
      group_push = accept && (quad || req_data.last_in);
   end

   always_comb begin
      buffer_in  = buffer_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (req_data.last_in) begin
            buffer_in  = '0;
            count_in   = '0;
            stopped_in = 1'b0;
         end else begin
            buffer_in  = buffer_post;
            count_in   = count_post;
            stopped_in = stopped_post;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff  <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         buffer_ff  <= buffer_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: sv/b64d_fifo.sv
module b64d_fifo #(
   parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::group_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                nonempty,
   output b64d_pkg::group_type pop_data
);
   import b64d_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   group_type      mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic           do_push, do_pop;

   always_comb begin
      full      = (fill_ff == CW'(DEPTH));
      nonempty  = (fill_ff != '0);
      pop_data  = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && nonempty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: sv/b64d_back.sv
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                group_ready,
   input  b64d_pkg::group_type group_data,
   output logic                group_take,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output b64d_pkg::rsp_type   rsp_data
);
   import b64d_pkg::*;

   group_type  cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic [1:0] last_idx;
   logic       at_end, fire;

   always_comb begin
      last_idx   = (cur_ff.count == 2'd0) ? 2'd0 : cur_ff.count - 2'd1;
      at_end     = (idx_ff == last_idx);
      fire       = rsp_pop && busy_ff;
      group_take = group_ready && (!busy_ff || (fire && at_end));

      rsp_empty           = !busy_ff;
      rsp_data.data_byte  = cur_ff.bytes[idx_ff];
      rsp_data.byte_valid = (cur_ff.count != 2'd0);
      rsp_data.last_out   = cur_ff.last && at_end;

      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (group_take) begin
         cur_in  = group_data;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: sv/base64_stream_decoder.sv
// Channel   Direction  Handshake            Word
// req_      in         req_push / req_full  req_type: char_in, last_in
// rsp_      out        rsp_pop / rsp_empty  rsp_type: data_byte, byte_valid, last_out
//
// One character word is accepted every cycle while req_full is low, and one result
// word leaves every cycle while rsp_pop is high and rsp_empty is low; the back end's
// one-byte-per-cycle serializer sets that output rate, so a stream of full quads
// runs at one character per cycle; results pass the queue and the back-end register.
// Reset is synchronous and empties the group queue and clears the decoder state.
// Either side may stall on its own: the group queue absorbs the difference until it
// fills, and then req_full holds off further characters.
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  b64d_pkg::req_type req_data,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   // The front end classifies each character and builds a group of up to three bytes
   // when a quad completes or the message ends.
   logic      accept;
   logic      group_push;
   group_type front_group;

   // The queue hands finished groups to the back end.
   logic      queue_full;
   logic      queue_nonempty;
   logic      group_take;
   group_type queue_group;

   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .group_push (group_push),
      .group_data (front_group)
   );

   b64d_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (group_push),
      .push_data (front_group),
      .pop       (group_take),
      .full      (queue_full),
      .nonempty  (queue_nonempty),
      .pop_data  (queue_group)
   );

   // The back end walks through a group one byte per pop and marks the message end.
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .group_ready (queue_nonempty),
      .group_data  (queue_group),
      .group_take  (group_take),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data)
   );

endmodule

// File: sv/b64d_checker.sv
module b64d_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_pop,
   input logic              rsp_empty,
   input b64d_pkg::rsp_type rsp_data
);
   import b64d_pkg::*;

   logic in_acc;
   assign in_acc = req_push && !req_full;

   // Nothing is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // An end marker always closes its message and carries a zero byte.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.byte_valid) |->
      (rsp_data.last_out && rsp_data.data_byte == 8'h00))
      else $error("malformed end marker");

   // With no characters arriving, an idle output stays idle.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !in_acc) ##1 (rsp_empty && !in_acc) |=> rsp_empty)
      else $error("result appeared without input");

   // The queue can only fill while the back end is busy with a group.
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled while output idle");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
